### rtl/mdp_pkg.sv
// Shared package of the Merkle-Damgard padder: codes, state enum,
// controller/datapath command and status structs, byte swap function.
// No dependencies.
`default_nettype none

package mdp_pkg;

	localparam int COUNT_W = 61;
	localparam int WORD_W  = 64;

	localparam logic [7:0] PAD_MSB  = 8'h80;
	localparam logic [7:0] PAD_LSB  = 8'h01;
	localparam logic [7:0] CNT_FIELD_BYTES = 8'd8;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [1:0] REG_BLOCK_LEN_LOG2   = 2'd0;
	localparam logic [1:0] REG_PAD_MSB_FIRST    = 2'd1;
	localparam logic [1:0] REG_COUNT_BIG_ENDIAN = 2'd2;
	localparam logic [1:0] REG_COUNTER_BYTES    = 2'd3;

	typedef enum logic {
		ST_DATA,
		ST_PAD
	} mdp_state_t;

	typedef struct packed {
		logic append;
		logic start_pad;
		logic emit;
	} mdp_cmd_t;

	typedef struct packed {
		logic word_full;
		logic pad_final;
	} mdp_sts_t;

	function automatic logic [WORD_W-1:0] swap64(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			r[8*k +: 8] = v[8*(7-k) +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/mdp_in_if.sv
// Message byte channel: valid/ready handshake with op and data byte.
// Depends on nothing.
`default_nettype none

interface mdp_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

### rtl/mdp_out_if.sv
// Block word channel: valid/ready handshake with 64-bit word and end flags.
// Depends on nothing.
`default_nettype none

interface mdp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_word;
	logic        block_end;
	logic        message_end;

	modport source (output valid, output block_word, output block_end,
		output message_end, input ready);
	modport sink (input valid, input block_word, input block_end,
		input message_end, output ready);
endinterface

`default_nettype wire

### rtl/merkle_damgard_padder.sv
// Merkle-Damgard length padder top level: controller plus datapath.
// Depends on mdp_pkg, mdp_in_if, mdp_out_if, mdp_ctrl, mdp_datapath.
//
//   port    | role         | carries
//   --------+--------------+-------------------------------------------
//   msg     | sink         | op, data_byte
//   blk     | source       | block_word, block_end, message_end
//   cfg_*   | write port   | cfg_index selects register, cfg_data value
//
// One word leaves every eighth data byte.
// A finish is accepted, then the padding words leave one at a time
// (up to two blocks of words) through the single output word register.
// No input is taken until the last padding word. A stalled output holds the word register and drops msg.ready.
// Reset clears the message state and loads the register defaults.
`default_nettype none

module merkle_damgard_padder #(
	parameter int MAX_BLOCK_BYTES = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mdp_in_if.sink          msg,
	mdp_out_if.source       blk,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import mdp_pkg::*;

	mdp_cmd_t cmd;
	mdp_sts_t sts;

	mdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_op     (msg.op),
		.in_ready  (msg.ready),
		.out_valid (blk.valid),
		.out_ready (blk.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mdp_datapath #(
		.MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (msg.data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.block_word  (blk.block_word),
		.block_end   (blk.block_end),
		.message_end (blk.message_end)
	);

endmodule

`default_nettype wire

### rtl/mdp_ctrl.sv
// Padder controller: data/pad state machine, input ready and output valid.
// Depends on mdp_pkg.
`default_nettype none

module mdp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_op,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mdp_pkg::mdp_cmd_t     cmd,
	input  wire mdp_pkg::mdp_sts_t sts
);
	import mdp_pkg::*;

	mdp_state_t state_q;
	mdp_state_t state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_DATA: begin
				if (accept && in_op == OP_FINISH) state_d = ST_PAD;
			end
			ST_PAD: begin
				if (out_free && sts.pad_final) state_d = ST_DATA;
			end
			default: state_d = ST_DATA;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.append    = 1'b0;
		cmd.start_pad = 1'b0;
		cmd.emit      = 1'b0;
		case (state_q)
			ST_DATA: begin
				in_ready      = out_free;
				cmd.append    = in_valid && out_free && in_op == OP_APPEND;
				cmd.start_pad = in_valid && out_free && in_op == OP_FINISH;
			end
			ST_PAD: begin
				cmd.emit = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DATA;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_free) out_valid_q <= (cmd.append && sts.word_full) || cmd.emit;
		end
	end

endmodule

`default_nettype wire

### rtl/mdp_datapath.sv
// Padder datapath: configuration registers, byte count, block position,
// word assembly, pad and length word generation, output word register.
// Depends on mdp_pkg.
`default_nettype none

module mdp_datapath #(
	parameter int MAX_BLOCK_BYTES = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire logic [7:0]        data_byte,
	input  wire mdp_pkg::mdp_cmd_t cmd,
	output mdp_pkg::mdp_sts_t      sts,
	output logic [63:0]            block_word,
	output logic                   block_end,
	output logic                   message_end
);
	import mdp_pkg::*;

	localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1) - 1;
	localparam int BL_W  = POS_W + 1;

	logic [2:0]         block_len_log2_q;
	logic               pad_msb_first_q;
	logic               count_big_endian_q;
	logic [7:0]         counter_bytes_q;

	logic [COUNT_W-1:0] byte_count_q;
	logic [POS_W-1:0]   pos_q;
	logic [WORD_W-1:0]  asm_q;
	logic               split_q;

	logic [63:0]        word_q;
	logic               bend_q;
	logic               mend_q;

	logic [2:0]         len_log2;
	logic [BL_W-1:0]    bl;
	logic [POS_W-1:0]   bl_mask;
	logic [POS_W-1:0]   p;
	logic [2:0]         lane;
	logic [7:0]         cb;
	logic               split;
	logic               bend;
	logic [WORD_W-1:0]  asm_next;
	logic [WORD_W-1:0]  cword;
	logic [7:0]         pad_byte;
	logic               pad_last;

	always_comb begin
		len_log2 = block_len_log2_q;
		if (len_log2 < 3'd3) len_log2 = 3'd3;
		if (len_log2 > 3'(POS_W)) len_log2 = 3'(POS_W);
	end

	assign bl      = BL_W'(1) << len_log2;
	assign bl_mask = POS_W'(bl - BL_W'(1));
	assign p       = pos_q & bl_mask;
	assign lane    = p[2:0];

	always_comb begin
		cb = counter_bytes_q;
		if (cb < CNT_FIELD_BYTES) cb = CNT_FIELD_BYTES;
		if (cb > 8'(bl)) cb = 8'(bl);
	end

	assign split    = (9'(p) + 9'(cb)) >= 9'(bl);
	assign bend     = (BL_W'(p) + BL_W'(1)) == bl;
	assign asm_next = asm_q | (WORD_W'(data_byte) << {lane, 3'b000});
	assign cword    = count_big_endian_q ? swap64({byte_count_q, 3'b000})
		: {byte_count_q, 3'b000};
	assign pad_byte = pad_msb_first_q ? PAD_MSB : PAD_LSB;
	assign pad_last = (pos_q | POS_W'(7)) == bl_mask;

	assign sts.word_full = lane == 3'd7;
	assign sts.pad_final = pad_last && !split_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_log2_q   <= 3'd6;
			pad_msb_first_q    <= 1'b1;
			count_big_endian_q <= 1'b1;
			counter_bytes_q    <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_LEN_LOG2:   block_len_log2_q   <= cfg_data[2:0];
				REG_PAD_MSB_FIRST:    pad_msb_first_q    <= cfg_data[0];
				REG_COUNT_BIG_ENDIAN: count_big_endian_q <= cfg_data[0];
				REG_COUNTER_BYTES:    counter_bytes_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			pos_q        <= '0;
			asm_q        <= '0;
			split_q      <= 1'b0;
		end else if (cmd.append) begin
			byte_count_q <= byte_count_q + COUNT_W'(1);
			if (lane == 3'd7) begin
				asm_q <= '0;
				pos_q <= bend ? '0 : p + POS_W'(1);
			end else begin
				asm_q <= asm_next;
				pos_q <= p + POS_W'(1);
			end
		end else if (cmd.start_pad) begin
			asm_q   <= asm_q | (WORD_W'(pad_byte) << {lane, 3'b000});
			pos_q   <= p;
			split_q <= split;
		end else if (cmd.emit) begin
			asm_q <= '0;
			if (pad_last && !split_q) begin
				byte_count_q <= '0;
				pos_q        <= '0;
			end else if (pad_last) begin
				pos_q   <= '0;
				split_q <= 1'b0;
			end else begin
				pos_q <= (pos_q | POS_W'(7)) + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && lane == 3'd7) begin
			word_q <= asm_next;
			bend_q <= bend;
			mend_q <= 1'b0;
		end else if (cmd.emit) begin
			word_q <= (pad_last && !split_q) ? cword : asm_q;
			bend_q <= pad_last;
			mend_q <= pad_last && !split_q;
		end
	end

	assign block_word  = word_q;
	assign block_end   = bend_q;
	assign message_end = mend_q;

endmodule

`default_nettype wire

### rtl/mdp_checker.sv
// Port-level checks of the padder and their bind to the top level.
// Depends on mdp_pkg and merkle_damgard_padder.
`default_nettype none

module mdp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        msg_valid,
	input wire logic        msg_ready,
	input wire logic        msg_op,
	input wire logic        blk_valid,
	input wire logic        blk_ready,
	input wire logic [63:0] blk_word,
	input wire logic        blk_block_end,
	input wire logic        blk_message_end
);
	import mdp_pkg::*;

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && !blk_ready |=> blk_valid && $stable(blk_word)
			&& $stable(blk_message_end))
		else $error("stalled word changed");

	a_msg_end_closes_block: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && blk_message_end |-> blk_block_end)
		else $error("message end without block end");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && !blk_ready |-> !msg_ready)
		else $error("input taken while output stalled");

	a_finish_pads: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg_op == OP_FINISH |=> !msg_ready)
		else $error("input taken right after finish");

endmodule

bind merkle_damgard_padder mdp_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.msg_valid       (msg.valid),
	.msg_ready       (msg.ready),
	.msg_op          (msg.op),
	.blk_valid       (blk.valid),
	.blk_ready       (blk.ready),
	.blk_word        (blk.block_word),
	.blk_block_end   (blk.block_end),
	.blk_message_end (blk.message_end)
);

`default_nettype wire

### dv/merkle_damgard_padder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for merkle_damgard_padder: message bytes and finishes in,
// padded 64-bit block words out, checked in order against an in-bench padding predictor.
// Depends on mdp_pkg, mdp_in_if, mdp_out_if and the padder RTL.

module merkle_damgard_padder_tb;
	import mdp_pkg::*;

	localparam int MAX_BLOCK_BYTES = 128;
	localparam int TOTAL_ITEMS     = 110;
	localparam int SETTLE_CYCLES   = 40;
	localparam int REPORT_LIMIT    = 10;

	typedef struct {
		logic       op;
		logic [7:0] data_byte;
	} msg_item_t;

	typedef struct {
		logic [63:0] block_word;
		logic        block_end;
		logic        message_end;
	} blk_word_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	mdp_in_if  msg_if();
	mdp_out_if blk_if();

	merkle_damgard_padder #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_if),
		.blk(blk_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the registers and message state
	logic [2:0]  cfg_len_log2    = 3'd6;
	logic        cfg_pad_msb     = 1'b1;
	logic        cfg_count_be    = 1'b1;
	logic [7:0]  cfg_field_bytes = 8'd8;
	logic [60:0] msg_bytes       = '0;
	int          blk_pos         = 0;
	logic [63:0] part_word       = '0;

	msg_item_t pending_items[$];
	blk_word_t padded_words[$];
	msg_item_t next_item;
	blk_word_t want;

	int src_gap        = 0;
	int sink_stall     = 0;
	int src_gap_pct    = 30;
	int sink_stall_pct = 30;

	int unsigned items_queued  = 0;
	int unsigned words_seen    = 0;
	int unsigned messages_done = 0;
	int unsigned config_writes = 0;
	int unsigned mismatches    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	function automatic int block_bytes();
		int l;
		l = cfg_len_log2;
		if (l < 3)
			l = 3;
		while (l > 3 && (1 << l) > MAX_BLOCK_BYTES)
			l--;
		return 1 << l;
	endfunction

	task automatic queue_word(input logic [63:0] w, input logic bend, input logic mend);
		blk_word_t e;
		e.block_word  = w;
		e.block_end   = bend;
		e.message_end = mend;
		padded_words.push_back(e);
	endtask

	task automatic predict_words(input logic op, input logic [7:0] db);
		int bl, words, p, lane, cb, i;
		logic [63:0] bits, cword, w;
		logic [7:0]  pad;
		logic        split;
		bl    = block_bytes();
		words = bl / 8;
		p     = blk_pos & (bl - 1);
		lane  = p & 7;
		if (op == OP_APPEND) begin
			part_word = part_word | (64'(db) << (8 * lane));
			msg_bytes = msg_bytes + 61'd1;
			p++;
			if (lane == 7) begin
				queue_word(part_word, p == bl, 1'b0);
				part_word = '0;
				if (p == bl)
					p = 0;
			end
			blk_pos = p;
		end else begin
			cb = cfg_field_bytes;
			if (cb < CNT_FIELD_BYTES)
				cb = CNT_FIELD_BYTES;
			if (cb > bl)
				cb = bl;
			bits = {msg_bytes, 3'b000};
			for (i = 0; i < 8; i++)
				cword[8*i +: 8] = cfg_count_be ? bits[8*(7-i) +: 8] : bits[8*i +: 8];
			pad   = cfg_pad_msb ? PAD_MSB : PAD_LSB;
			w     = part_word | (64'(pad) << (8 * lane));
			split = (p >= bl - cb);
			if (split) begin
				for (i = p / 8; i < words; i++) begin
					queue_word(w, i == words - 1, 1'b0);
					w = '0;
				end
				for (i = 0; i + 1 < words; i++)
					queue_word('0, 1'b0, 1'b0);
			end else begin
				for (i = p / 8; i + 1 < words; i++) begin
					queue_word(w, 1'b0, 1'b0);
					w = '0;
				end
			end
			queue_word(cword, 1'b1, 1'b1);
			msg_bytes = '0;
			blk_pos   = 0;
			part_word = '0;
			messages_done++;
		end
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] %s", $time, what);
	endtask

	// driver: one message item per handshake, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_if.valid     <= 1'b0;
			msg_if.op        <= OP_APPEND;
			msg_if.data_byte <= 8'h00;
			src_gap = 0;
		end else begin
			if (msg_if.valid && msg_if.ready)
				predict_words(msg_if.op, msg_if.data_byte);
			if (!msg_if.valid || msg_if.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					msg_if.valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					msg_if.valid     <= 1'b1;
					msg_if.op        <= next_item.op;
					msg_if.data_byte <= next_item.data_byte;
					src_gap = ($urandom_range(0, 99) < src_gap_pct) ? draw_gap() : 0;
				end else begin
					msg_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_if.ready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (blk_if.valid && blk_if.ready) begin
				words_seen++;
				if (padded_words.size() == 0) begin
					note_mismatch($sformatf("unexpected word %h end %b msg_end %b",
						blk_if.block_word, blk_if.block_end, blk_if.message_end));
				end else begin
					want = padded_words.pop_front();
					if (blk_if.block_word !== want.block_word ||
						blk_if.block_end !== want.block_end ||
						blk_if.message_end !== want.message_end)
						note_mismatch($sformatf(
							"word %0d: expected %h/%b/%b got %h/%b/%b", words_seen,
							want.block_word, want.block_end, want.message_end,
							blk_if.block_word, blk_if.block_end, blk_if.message_end));
				end
			end
			if (sink_stall > 0) begin
				sink_stall--;
				blk_if.ready <= 1'b0;
			end else begin
				blk_if.ready <= 1'b1;
				if ($urandom_range(0, 99) < sink_stall_pct)
					sink_stall = draw_gap();
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		msg_item_t it;
		it.op        = OP_APPEND;
		it.data_byte = b;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic send_finish();
		msg_item_t it;
		it.op        = OP_FINISH;
		it.data_byte = 8'($urandom);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || msg_if.valid || padded_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_BLOCK_LEN_LOG2:   cfg_len_log2    = val[2:0];
			REG_PAD_MSB_FIRST:    cfg_pad_msb     = val[0];
			REG_COUNT_BIG_ENDIAN: cfg_count_be    = val[0];
			REG_COUNTER_BYTES:    cfg_field_bytes = val;
			default: ;
		endcase
		config_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int i, j, n_msgs, len, bl, room;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_BLOCK_LEN_LOG2;
		cfg_data         = 8'h00;
		msg_if.valid     = 1'b0;
		msg_if.op        = OP_APPEND;
		msg_if.data_byte = 8'h00;
		blk_if.ready     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// default 64-byte block: empty message, then a short one
		send_finish();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_finish();
		wait_idle();

		// undersized block length and counter field, LSB pad, little endian
		write_reg(REG_BLOCK_LEN_LOG2, 8'h00);
		write_reg(REG_PAD_MSB_FIRST, 8'h00);
		write_reg(REG_COUNT_BIG_ENDIAN, 8'h00);
		write_reg(REG_COUNTER_BYTES, 8'h00);
		for (i = 0; i < 9; i++)
			send_byte(8'(8'h1D * i + 8'hF0));
		send_finish();
		wait_idle();

		// largest block, counter field past the block, then resize mid-message
		write_reg(REG_BLOCK_LEN_LOG2, 8'hFF);
		write_reg(REG_PAD_MSB_FIRST, 8'h01);
		write_reg(REG_COUNT_BIG_ENDIAN, 8'h01);
		write_reg(REG_COUNTER_BYTES, 8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h5A);
		wait_idle();
		write_reg(REG_BLOCK_LEN_LOG2, 8'h03);
		write_reg(REG_COUNTER_BYTES, 8'h09);
		for (i = 0; i < 6; i++)
			send_byte(8'($urandom));
		send_finish();
		wait_idle();

		while (items_queued < TOTAL_ITEMS) begin
			write_reg(REG_BLOCK_LEN_LOG2, {5'($urandom), 3'($urandom_range(0, 7))});
			write_reg(REG_PAD_MSB_FIRST, 8'($urandom));
			write_reg(REG_COUNT_BIG_ENDIAN, 8'($urandom));
			write_reg(REG_COUNTER_BYTES,
				$urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(8, 16)));
			src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
			sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
			n_msgs = $urandom_range(1, 3);
			bl     = block_bytes();
			for (i = 0; i < n_msgs; i++) begin
				len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 20)
					: $urandom_range(0, 2 * bl + 8);
				room = TOTAL_ITEMS - int'(items_queued);
				if (len > room)
					len = (room > 0) ? room : 0;
				for (j = 0; j < len; j++)
					send_byte(8'($urandom));
				// leave some messages open across the next register change
				if ($urandom_range(0, 9) != 0)
					send_finish();
			end
			wait_idle();
		end

		if (padded_words.size() != 0) begin
			$display("%0d predicted words never arrived", padded_words.size());
			mismatches += padded_words.size();
		end
		$display("ran %0d bytes and finishes, %0d padded messages, %0d register writes",
			items_queued, messages_done, config_writes);
		$display("checked %0d block words, %0d mismatches", words_seen, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("run timed out with %0d words outstanding", padded_words.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
